[rtl/vrap_pkg.sv]
// Shared types, codes and widths of the video RAM access port.
// Used by vrap_core, vrap_out_skid and video_ram_access_port; no dependencies.
`timescale 1ns / 1ps

package vrap_pkg;

    localparam int PAGE_ADDR_BITS = 14;
    localparam int MAX_PAGES_DEF  = 8;
    localparam int PAGE_W         = 3;
    localparam int DATA_W         = 8;
    localparam int MODE_W         = 2;
    localparam int REG_IDX_W      = 6;
    localparam int CFG_W          = 4;

    localparam logic [CFG_W-1:0] PAGED_MODE_MIN  = 4'd4;
    localparam logic [CFG_W-1:0] SCREEN_MODE_RST = 4'd0;
    localparam logic [CFG_W-1:0] PAGE_COUNT_RST  = 4'd8;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_CTRL  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // Top two bits of the second control byte
    typedef enum logic [1:0] {
        CTL_READ_ADDR  = 2'b00,
        CTL_WRITE_ADDR = 2'b01,
        CTL_REG_WRITE  = 2'b10,
        CTL_IGNORE     = 2'b11
    } t_ctl_kind;

    typedef enum logic [0:0] {
        CFG_SCREEN_MODE = 1'b0,
        CFG_PAGE_COUNT  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [CFG_W-1:0] screen_mode;
        logic [CFG_W-1:0] page_count;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0]    reg_value;
        logic [REG_IDX_W-1:0] reg_index;
        logic                 reg_write_valid;
        logic [DATA_W-1:0]    read_data;
    } t_result;

endpackage

[rtl/vrap_core.sv]
// Access state and video memory of the video RAM access port.
// Depends on vrap_pkg.
`timescale 1ns / 1ps

module vrap_core #(
    parameter int MAX_PAGES = vrap_pkg::MAX_PAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vrap_pkg::t_cfg               i_cfg,
    input  logic                         i_valid,
    input  logic [vrap_pkg::MODE_W-1:0]  i_mode,
    input  logic [vrap_pkg::DATA_W-1:0]  i_data,
    output vrap_pkg::t_result            o_result
);

    localparam int MEM_DEPTH = MAX_PAGES << vrap_pkg::PAGE_ADDR_BITS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int AW        = vrap_pkg::PAGE_ADDR_BITS;
    localparam int PW        = vrap_pkg::PAGE_W;
    localparam int DW        = vrap_pkg::DATA_W;

    // Fold a page number into the pages that exist (at most seven steps)
    function automatic logic [PW-1:0] page_mod(input logic [PW-1:0] p);
        logic [PW:0] v;
        v = {1'b0, p};
        for (int i = 0; i < 8; i++) begin
            if (32'(v) >= MAX_PAGES) begin
                v = v - (PW+1)'(MAX_PAGES);
            end
        end
        return v[PW-1:0];
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input logic [PW-1:0] p,
                                                   input logic [AW-1:0] a);
        return MEM_AW'((32'(page_mod(p)) << AW) | 32'(a));
    endfunction

    logic [DW-1:0] r_mem [0:MEM_DEPTH-1];
    logic [DW-1:0] r_rdata;
    logic          r_pend;
    logic [DW-1:0] r_buf;
    logic [AW-1:0] r_addr;
    logic [PW-1:0] r_page;
    logic          r_wsetup;
    logic          r_expect;
    logic [DW-1:0] r_latch;

    logic [AW-1:0] n_addr;
    logic [PW-1:0] n_page;
    logic          n_wsetup;
    logic          n_expect;
    logic [DW-1:0] n_latch;

    logic              mem_re;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_raddr;
    logic [MEM_AW-1:0] mem_waddr;
    logic              buf_load;
    logic [DW-1:0]     cur_buf;
    logic [AW-1:0]     addr_inc;
    logic [AW-1:0]     ctl_addr;
    logic [AW-1:0]     ctl_inc;
    logic [PW-1:0]     page_mask;
    logic [PW-1:0]     page_next;
    logic              paged;
    vrap_pkg::t_ctl_kind ctl_kind;

    // Read data still in flight stands in for the buffer
    assign cur_buf   = r_pend ? r_rdata : r_buf;
    assign addr_inc  = r_addr + AW'(1);
    assign ctl_addr  = {i_data[AW-DW-1:0], r_latch};
    assign ctl_inc   = ctl_addr + AW'(1);
    assign page_mask = i_cfg.page_count[PW-1:0] - PW'(1);
    assign page_next = (r_page + PW'(1)) & page_mask;
    assign paged     = i_cfg.screen_mode >= vrap_pkg::PAGED_MODE_MIN;
    assign ctl_kind  = vrap_pkg::t_ctl_kind'(i_data[DW-1:DW-2]);

    always_comb begin
        n_addr    = r_addr;
        n_page    = r_page;
        n_wsetup  = r_wsetup;
        n_expect  = r_expect;
        n_latch   = r_latch;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_raddr = mem_addr(r_page, r_addr);
        mem_waddr = mem_addr(r_page, r_addr);
        buf_load  = 1'b0;
        o_result  = '0;
        case (vrap_pkg::t_mode'(i_mode))
            vrap_pkg::MODE_READ: begin
                o_result.read_data = cur_buf;
                n_expect = 1'b1;
                mem_re   = 1'b1;
                n_addr   = addr_inc;
                if (addr_inc == '0 && paged) begin
                    n_page = page_next;
                end
            end
            vrap_pkg::MODE_WRITE: begin
                n_expect = 1'b1;
                mem_we   = 1'b1;
                if (r_wsetup) begin
                    buf_load = 1'b1;
                end else begin
                    // refill first, then store one past it on the old page
                    mem_re    = 1'b1;
                    mem_waddr = mem_addr(r_page, addr_inc);
                end
                n_addr = addr_inc;
                if (addr_inc == '0 && paged) begin
                    n_page = page_next;
                end
            end
            vrap_pkg::MODE_CTRL: begin
                if (r_expect) begin
                    n_latch  = i_data;
                    n_expect = 1'b0;
                end else begin
                    n_expect = 1'b1;
                    case (ctl_kind)
                        vrap_pkg::CTL_REG_WRITE: begin
                            o_result.reg_write_valid = 1'b1;
                            o_result.reg_index = i_data[vrap_pkg::REG_IDX_W-1:0];
                            o_result.reg_value = r_latch;
                        end
                        vrap_pkg::CTL_READ_ADDR: begin
                            n_wsetup  = 1'b0;
                            mem_re    = 1'b1;
                            mem_raddr = mem_addr(r_page, ctl_addr);
                            n_addr    = ctl_inc;
                            if (ctl_inc == '0 && paged) begin
                                n_page = page_next;
                            end
                        end
                        vrap_pkg::CTL_WRITE_ADDR: begin
                            n_wsetup = 1'b1;
                            n_addr   = ctl_addr;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_buf    <= '0;
            r_addr   <= '0;
            r_page   <= '0;
            r_wsetup <= 1'b0;
            r_expect <= 1'b1;
            r_latch  <= '0;
        end else begin
            // a written byte replaces any read data still in flight
            if (i_valid && buf_load) begin
                r_buf <= i_data;
            end else if (r_pend) begin
                r_buf <= r_rdata;
            end
            r_pend <= i_valid && mem_re;
            if (i_valid) begin
                r_addr   <= n_addr;
                r_page   <= n_page;
                r_wsetup <= n_wsetup;
                r_expect <= n_expect;
                r_latch  <= n_latch;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && mem_we) begin
            r_mem[mem_waddr] <= i_data;
        end
        if (i_valid && mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

[rtl/vrap_out_skid.sv]
// Two-entry output register and skid stage for result items.
// Depends on vrap_pkg.
`timescale 1ns / 1ps

module vrap_out_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vrap_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output vrap_pkg::t_result o_data
);

    logic              r_out_valid;
    logic              r_skid_valid;
    vrap_pkg::t_result r_out;
    vrap_pkg::t_result r_skid;
    logic              out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_valid) begin
                r_out <= i_data;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_data;
        end
    end

endmodule

[rtl/video_ram_access_port.sv]
// Top level of the video RAM access port: configuration registers and stream wiring.
// Depends on vrap_pkg, vrap_core and vrap_out_skid.
`timescale 1ns / 1ps

// Processor side of a video chip's memory port. Each input item is one processor
// access: tuser carries the access kind (data read, data write, control write) and
// tdata the byte written. Every item yields exactly one result item, which appears
// in the output register the cycle after the item is taken when that register is
// free, or in the skid entry when a result still waits there. The block takes one
// item per clock cycle while results drain: the video memory has one write and one
// read port with a registered read, and a read-ahead byte still in flight from the
// memory is forwarded straight into the next data read, so nothing waits on the
// memory. The two-entry output stage keeps accepting while one result waits
// downstream; with both entries full, input is held until the output moves.
// Video memory holds MAX_PAGES pages of 16 KiB with no reset or clearing pass; a read
// of a byte never written returns an arbitrary value. Configuration (screen mode, page
// count) uses the plain write port; the user writes it only while idle, unenforced.

module video_ram_access_port #(
    parameter int MAX_PAGES = vrap_pkg::MAX_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] read_data, [13:8] reg_index,
                                        // [21:14] reg_value, [23:22] zero
    output logic [0:0]  m_axis_tuser    // [0] reg_write_valid
);

    vrap_pkg::t_cfg    r_cfg;
    vrap_pkg::t_result core_res;
    vrap_pkg::t_result out_res;
    logic              in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Hold the configuration; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_mode <= vrap_pkg::SCREEN_MODE_RST;
            r_cfg.page_count  <= vrap_pkg::PAGE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (vrap_pkg::t_cfg_index'(i_cfg_index))
                vrap_pkg::CFG_SCREEN_MODE: r_cfg.screen_mode <= i_cfg_wdata;
                vrap_pkg::CFG_PAGE_COUNT:  r_cfg.page_count  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Decode the access, update address and buffer, drive the memory
    vrap_core #(
        .MAX_PAGES (MAX_PAGES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (in_acc),
        .i_mode   (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_result (core_res)
    );

    // Register the result; the skid entry absorbs a stalled output
    vrap_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_acc),
        .o_ready (s_axis_tready),
        .i_data  (core_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {2'b00, out_res.reg_value, out_res.reg_index, out_res.read_data};
    assign m_axis_tuser = out_res.reg_write_valid;

    // An empty output register means the skid entry is empty too
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    a_regwr_only_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser != vrap_pkg::MODE_CTRL) |-> !core_res.reg_write_valid)
        else $error("register write requested outside a control access");

    a_rdata_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser != vrap_pkg::MODE_READ) |-> (core_res.read_data == '0))
        else $error("read data nonzero outside a data read");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !m_axis_tvalid) |=> m_axis_tvalid)
        else $error("accepted item did not reach the output register");

endmodule
